@@ hdl/udc_pkg.sv @@
`default_nettype none

package udc_pkg;

    localparam int FREQ_BITS_DEF = 26;
    localparam int BAUD_W        = 24;
    localparam int BAUD2_W       = BAUD_W + 1;
    localparam int DIVISOR_W     = 12;
    localparam int EXP_W         = 4;
    localparam int EIDX_W        = 4;

    // The rate limits are the clock over 8 and over 4194304, halved again at normal speed.
    localparam int MAX_SHIFT     = 3;
    localparam int MIN_SHIFT     = 22;

    // The exponent is carried as an index from zero, biased by seven.
    localparam int EXP_OFFSET    = 7;
    localparam int EXP_STEPS     = 14;
    localparam int DEEP_LAST     = EXP_OFFSET - 3;
    localparam int MAX_DEN_SHIFT = 10;
    localparam int DEN_W         = BAUD2_W + MAX_DEN_SHIFT;

    localparam logic [31:0] CLOCK_HZ_RESET = 32'd32000000;

    typedef enum logic [0:0] {
        REG_CLOCK_HZ     = 1'b0,
        REG_DOUBLE_SPEED = 1'b1
    } cfg_reg_t;

    typedef logic [EIDX_W-1:0] eidx_t;

    function automatic int num_width(input int freq_bits);
        return ((freq_bits + 4 > DEN_W) ? freq_bits + 4 : DEN_W) + 1;
    endfunction

    function automatic int latency(input int freq_bits);
        return freq_bits + num_width(freq_bits) + 5;
    endfunction

    function automatic logic [31:0] exp_limit(input eidx_t idx);
        logic [31:0] lim;
        case (idx)
            4'd0:    lim = 32'd255;
            4'd1:    lim = 32'd511;
            4'd2:    lim = 32'd1023;
            4'd3:    lim = 32'd2047;
            4'd4:    lim = 32'd4095;
            4'd5:    lim = 32'd8190;
            4'd6:    lim = 32'd16380;
            4'd7:    lim = 32'd32760;
            4'd8:    lim = 32'd65520;
            4'd9:    lim = 32'd131040;
            4'd10:   lim = 32'd262080;
            4'd11:   lim = 32'd524160;
            4'd12:   lim = 32'd1048320;
            4'd13:   lim = 32'd2096640;
            default: lim = 32'hFFFF_FFFF;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

@@ hdl/udc_div_cell.sv @@
`default_nettype none

module udc_div_cell
    import udc_pkg::*;
#(
    parameter int DW = DEN_W,
    parameter int NW = DEN_W + 1,
    parameter int PW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [NW-1:0] in_quo,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_num,
    output logic [NW-1:0] out_quo,
    output logic [DW-1:0] out_den,
    output logic [PW-1:0] out_side
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] num_next;
    logic [NW-1:0] quo_reg;
    logic [NW-1:0] quo_next;
    logic [DW-1:0] den_reg;
    logic [PW-1:0] side_reg;

    always_comb
    begin
        trial    = {in_rem, in_num[NW-1]};
        diff     = trial - {1'b0, in_den};
        fits     = (trial >= {1'b0, in_den});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        num_next = {in_num[NW-2:0], 1'b0};
        quo_next = {in_quo[NW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

@@ hdl/udc_div_chain.sv @@
`default_nettype none

module udc_div_chain
    import udc_pkg::*;
#(
    parameter int DW = DEN_W,
    parameter int NW = DEN_W + 1,
    parameter int PW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [PW-1:0] out_side
);

    // One quotient bit is settled in each cell, most significant first.
    logic          valid_w [0:NW];
    logic [DW-1:0] rem_w   [0:NW];
    logic [NW-1:0] num_w   [0:NW];
    logic [NW-1:0] quo_w   [0:NW];
    logic [DW-1:0] den_w   [0:NW];
    logic [PW-1:0] side_w  [0:NW];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = '0;
    assign num_w[0]   = in_num;
    assign quo_w[0]   = '0;
    assign den_w[0]   = in_den;
    assign side_w[0]  = in_side;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        udc_div_cell #(
            .DW (DW),
            .NW (NW),
            .PW (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[i]),
            .in_rem    (rem_w[i]),
            .in_num    (num_w[i]),
            .in_quo    (quo_w[i]),
            .in_den    (den_w[i]),
            .in_side   (side_w[i]),
            .out_valid (valid_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_num   (num_w[i+1]),
            .out_quo   (quo_w[i+1]),
            .out_den   (den_w[i+1]),
            .out_side  (side_w[i+1])
        );
    end

    assign out_valid = valid_w[NW];
    assign out_quo   = quo_w[NW];
    assign out_side  = side_w[NW];

endmodule

`default_nettype wire

@@ hdl/usart_baud_divisor_calc.sv @@
`default_nettype none

// Channel        Ports                                      Transaction
// request        start, busy, baud_rate                     start high while busy low
// result         done, supported, divisor, scale_exponent   done high for one cycle
// configuration  cfg_we, cfg_index, cfg_data                cfg_we high
//
// A new request is taken in every cycle; busy stays low.
// Each request passes through one cell per quotient bit in each of the two divider chains
// and five register stages around them.
// Results leave in request order and cannot be held off by the receiver.
// Reset returns the clock register to 32 MHz, clears double speed and empties the pipeline.

module usart_baud_divisor_calc
    import udc_pkg::*;
#(
    parameter int FREQ_BITS = FREQ_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [BAUD_W-1:0]       baud_rate,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [FREQ_BITS-1:0]    cfg_data,
    output logic                    done,
    output logic                    supported,
    output logic [DIVISOR_W-1:0]    divisor,
    output logic signed [EXP_W-1:0] scale_exponent
);

    localparam int NUM_W = num_width(FREQ_BITS);
    localparam int CMP_W = (FREQ_BITS > BAUD_W) ? FREQ_BITS : BAUD_W;
    localparam int R_PW  = 1 + BAUD2_W;
    localparam int D_PW  = 1 + EIDX_W;

    logic                 accept;
    logic [FREQ_BITS-1:0] clock_hz_reg;
    logic                 double_speed_reg;

    logic [FREQ_BITS-1:0] rate_ceiling;
    logic [FREQ_BITS-1:0] rate_floor;
    logic                 in_ok;
    logic [BAUD2_W-1:0]   baud2;

    logic                 s1_valid_reg;
    logic                 s1_ok_reg;
    logic [BAUD2_W-1:0]   s1_baud2_reg;

    logic                 r_valid;
    logic [FREQ_BITS-1:0] ratio;
    logic [R_PW-1:0]      r_side;

    eidx_t                eidx_next;
    logic                 e_valid_reg;
    logic                 e_ok_reg;
    logic [BAUD2_W-1:0]   e_baud2_reg;
    eidx_t                e_idx_reg;

    logic [FREQ_BITS-1:0] cpu_adj_next;
    logic                 p1_valid_reg;
    logic                 p1_ok_reg;
    logic [BAUD2_W-1:0]   p1_baud2_reg;
    eidx_t                p1_idx_reg;
    logic [FREQ_BITS-1:0] p1_cpu_adj_reg;

    logic [NUM_W-1:0]     num_next;
    logic [DEN_W-1:0]     den_next;
    eidx_t                sh_num;
    eidx_t                sh_den;
    logic [FREQ_BITS-1:0] num_base;
    logic                 p2_valid_reg;
    logic                 p2_ok_reg;
    eidx_t                p2_idx_reg;
    logic [NUM_W-1:0]     p2_num_reg;
    logic [DEN_W-1:0]     p2_den_reg;

    logic                 d_valid;
    logic [NUM_W-1:0]     quo;
    logic [D_PW-1:0]      d_side;
    logic                 d_ok;
    eidx_t                d_idx;
    logic                 d_pos;
    logic [DIVISOR_W-1:0] div_val;

    logic                 done_reg;
    logic                 supported_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [EXP_W-1:0]     exp_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg     <= FREQ_BITS'(CLOCK_HZ_RESET);
            double_speed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CLOCK_HZ:     clock_hz_reg     <= cfg_data;
                REG_DOUBLE_SPEED: double_speed_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Range check on the raw request; a zero rate is refused here, though it still passes through the dividers.
    always_comb
    begin
        if (double_speed_reg)
        begin
            rate_ceiling = clock_hz_reg >> MAX_SHIFT;
            rate_floor   = clock_hz_reg >> MIN_SHIFT;
            baud2        = {1'b0, baud_rate};
        end
        else
        begin
            rate_ceiling = clock_hz_reg >> (MAX_SHIFT + 1);
            rate_floor   = clock_hz_reg >> (MIN_SHIFT + 1);
            baud2        = {baud_rate, 1'b0};
        end
        in_ok = (baud_rate != '0)
              && (CMP_W'(baud_rate) <= CMP_W'(rate_ceiling))
              && (CMP_W'(baud_rate) >= CMP_W'(rate_floor));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg    <= in_ok;
        s1_baud2_reg <= baud2;
    end

    udc_div_chain #(
        .DW (BAUD2_W),
        .NW (FREQ_BITS),
        .PW (R_PW)
    ) u_ratio_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_num    (clock_hz_reg),
        .in_den    (s1_baud2_reg),
        .in_side   ({s1_ok_reg, s1_baud2_reg}),
        .out_valid (r_valid),
        .out_quo   (ratio),
        .out_side  (r_side)
    );

    // The lowest exponent whose limit lies above the clock-to-rate ratio wins.
    always_comb
    begin
        eidx_next = eidx_t'(EXP_STEPS);
        for (int k = EXP_STEPS - 1; k >= 0; k--)
        begin
            if (32'(ratio) < exp_limit(eidx_t'(k)))
            begin
                eidx_next = eidx_t'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        e_ok_reg    <= r_side[R_PW-1];
        e_baud2_reg <= r_side[BAUD2_W-1:0];
        e_idx_reg   <= eidx_next;
    end

    assign cpu_adj_next = clock_hz_reg - FREQ_BITS'({e_baud2_reg, 3'b000});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_ok_reg      <= e_ok_reg;
        p1_baud2_reg   <= e_baud2_reg;
        p1_idx_reg     <= e_idx_reg;
        p1_cpu_adj_reg <= cpu_adj_next;
    end

    // Deep negative exponents scale the numerator; the others scale the rate instead.
    always_comb
    begin
        sh_num   = eidx_t'(DEEP_LAST) - p1_idx_reg;
        sh_den   = p1_idx_reg - eidx_t'(DEEP_LAST);
        num_base = (p1_idx_reg < eidx_t'(EXP_OFFSET)) ? p1_cpu_adj_reg : clock_hz_reg;
        if (p1_idx_reg <= eidx_t'(DEEP_LAST))
        begin
            den_next = DEN_W'(p1_baud2_reg);
            num_next = (NUM_W'(p1_cpu_adj_reg) << sh_num) + NUM_W'(p1_baud2_reg >> 1);
        end
        else
        begin
            den_next = DEN_W'(p1_baud2_reg) << sh_den;
            num_next = NUM_W'(num_base) + NUM_W'(den_next >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_ok_reg  <= p1_ok_reg;
        p2_idx_reg <= p1_idx_reg;
        p2_num_reg <= num_next;
        p2_den_reg <= den_next;
    end

    udc_div_chain #(
        .DW (DEN_W),
        .NW (NUM_W),
        .PW (D_PW)
    ) u_divisor_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .in_num    (p2_num_reg),
        .in_den    (p2_den_reg),
        .in_side   ({p2_ok_reg, p2_idx_reg}),
        .out_valid (d_valid),
        .out_quo   (quo),
        .out_side  (d_side)
    );

    always_comb
    begin
        d_ok    = d_side[D_PW-1];
        d_idx   = d_side[EIDX_W-1:0];
        d_pos   = (d_idx >= eidx_t'(EXP_OFFSET));
        div_val = quo[DIVISOR_W-1:0] - DIVISOR_W'(d_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        supported_reg <= d_ok;
        divisor_reg   <= d_ok ? div_val : '0;
        exp_reg       <= d_ok ? (EXP_W'(d_idx) - EXP_W'(EXP_OFFSET)) : '0;
    end

    assign done           = done_reg;
    assign supported      = supported_reg;
    assign divisor        = divisor_reg;
    assign scale_exponent = exp_reg;

endmodule

`default_nettype wire

@@ hdl/udc_checker.sv @@
`default_nettype none

module udc_checker
    import udc_pkg::*;
#(
    parameter int LATENCY = latency(FREQ_BITS_DEF)
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic [BAUD_W-1:0]       baud_rate,
    input wire logic                    done,
    input wire logic                    supported,
    input wire logic [DIVISOR_W-1:0]    divisor,
    input wire logic signed [EXP_W-1:0] scale_exponent
);

    // Every result belongs to an earlier request taken while busy was low.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && rst_n, LATENCY))
        else $error("result without a matching request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !supported) |-> (divisor == '0 && scale_exponent == '0))
        else $error("refused rate carries a non-zero divisor or exponent");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(baud_rate == '0, LATENCY)) |-> !supported)
        else $error("zero rate reported as supported");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && supported) |-> (scale_exponent != {1'b1, {(EXP_W - 1){1'b0}}}))
        else $error("exponent outside its range");

endmodule

bind usart_baud_divisor_calc udc_checker #(
    .LATENCY (udc_pkg::latency(FREQ_BITS))
) u_udc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .baud_rate      (baud_rate),
    .done           (done),
    .supported      (supported),
    .divisor        (divisor),
    .scale_exponent (scale_exponent)
);

`default_nettype wire

@@ tb/usart_baud_divisor_calc_checker.sv @@
`timescale 1ns / 1ps

module usart_baud_divisor_calc_checker
    import udc_pkg::*;
#(
    parameter int FREQ_BITS = FREQ_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [BAUD_W-1:0]       baud_rate,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [FREQ_BITS-1:0]    cfg_data,
    input  logic                    done,
    input  logic                    supported,
    input  logic [DIVISOR_W-1:0]    divisor,
    input  logic signed [EXP_W-1:0] scale_exponent,
    input  logic                    end_of_test,
    output int                      error_count,
    output int                      outstanding
);

    localparam logic [FREQ_BITS-1:0] CLOCK_AFTER_RESET = FREQ_BITS'(32000000);
    localparam longint unsigned      CLKS_PER_BIT      = 8;
    localparam longint unsigned      SLOWEST_DIVIDER   = 4194304;
    localparam longint unsigned      FIRST_RATIO_LIMIT = 255;

    typedef struct packed {
        logic [BAUD_W-1:0]       baud;
        logic                    supported;
        logic [DIVISOR_W-1:0]    divisor;
        logic signed [EXP_W-1:0] scale_exponent;
    } bsel_result_t;

    logic [FREQ_BITS-1:0] clock_hz_copy;
    logic                 double_speed_copy;
    logic                 tail_checked;
    bsel_result_t         bsel_q[$];
    bsel_result_t         oldest;

    function automatic bsel_result_t predict_bsel(input longint unsigned clk_hz,
                                                  input logic dbl,
                                                  input logic [BAUD_W-1:0] baud);
        longint unsigned fastest;
        longint unsigned slowest;
        longint unsigned rate;
        longint unsigned limit;
        longint unsigned ratio;
        longint unsigned spare;
        longint unsigned den;
        longint unsigned div;
        int              e;
        bsel_result_t    r;
        r = '0;
        r.baud = baud;
        fastest = clk_hz / CLKS_PER_BIT;
        slowest = clk_hz / SLOWEST_DIVIDER;
        if (!dbl)
        begin
            fastest = fastest / 2;
            slowest = slowest / 2;
        end
        rate = baud;
        if (rate == 0 || rate > fastest || rate < slowest)
            return r;
        if (!dbl)
            rate = rate * 2;
        limit = FIRST_RATIO_LIMIT;
        ratio = clk_hz / rate;
        e = -7;
        while (e < 7 && ratio >= limit)
        begin
            limit = limit << 1;
            if (e < -3)
                limit = limit | 1;
            e = e + 1;
        end
        if (e < 0)
        begin
            spare = clk_hz - CLKS_PER_BIT * rate;
            if (e <= -3)
                div = ((spare << (-e - 3)) + rate / 2) / rate;
            else
            begin
                den = rate << (e + 3);
                div = (spare + den / 2) / den;
            end
        end
        else
        begin
            den = rate << (e + 3);
            div = (clk_hz + den / 2) / den - 1;
        end
        r.supported      = 1'b1;
        r.divisor        = div[DIVISOR_W-1:0];
        r.scale_exponent = e[EXP_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsel_q.delete();
            error_count        = 0;
            clock_hz_copy     <= CLOCK_AFTER_RESET;
            double_speed_copy <= 1'b0;
            tail_checked      <= 1'b0;
            outstanding       <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CLOCK_HZ:     clock_hz_copy     <= cfg_data;
                    REG_DOUBLE_SPEED: double_speed_copy <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (start && !busy)
                bsel_q.push_back(predict_bsel(clock_hz_copy, double_speed_copy, baud_rate));
            if (done)
            begin
                if (bsel_q.size() == 0)
                    report_mismatch("result transaction with no request outstanding");
                else
                begin
                    oldest = bsel_q.pop_front();
                    if (supported !== oldest.supported)
                        report_mismatch($sformatf("baud %0d: supported %b, expected %b",
                                                  oldest.baud, supported, oldest.supported));
                    if (divisor !== oldest.divisor)
                        report_mismatch($sformatf("baud %0d: divisor %0d, expected %0d",
                                                  oldest.baud, divisor, oldest.divisor));
                    if (scale_exponent !== oldest.scale_exponent)
                        report_mismatch($sformatf("baud %0d: scale exponent %0d, expected %0d",
                                                  oldest.baud, scale_exponent,
                                                  oldest.scale_exponent));
                end
            end
            if (end_of_test && !tail_checked)
            begin
                tail_checked <= 1'b1;
                if (bsel_q.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived", bsel_q.size()));
            end
            outstanding <= bsel_q.size();
        end
    end

endmodule

@@ tb/usart_baud_divisor_calc_tb.sv @@
`timescale 1ns / 1ps

module usart_baud_divisor_calc_tb;
    import udc_pkg::*;

    localparam int              FREQ_W         = FREQ_BITS_DEF;
    localparam int              SETTLE_CYCLES  = latency(FREQ_W) + 20;
    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              SEGMENT_ITEMS  = 95;
    localparam longint unsigned CLOCK_MAX      = 67108863;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    start       = 1'b0;
    logic [BAUD_W-1:0]       baud_rate   = '0;
    logic                    cfg_we      = 1'b0;
    cfg_reg_t                cfg_index   = REG_CLOCK_HZ;
    logic [FREQ_W-1:0]       cfg_data    = '0;
    logic                    end_of_test = 1'b0;
    logic                    busy;
    logic                    done;
    logic                    supported;
    logic [DIVISOR_W-1:0]    divisor;
    logic signed [EXP_W-1:0] scale_exponent;
    int                      error_count;
    int                      outstanding;

    int                      sender_idle_pct = 0;
    int                      quiet_cycles    = 0;
    longint unsigned         cur_clock_hz    = 32000000;
    logic                    cur_double      = 1'b0;
    int                      phase_idle[3]   = '{8, 84, 0};

    usart_baud_divisor_calc #(.FREQ_BITS(FREQ_W)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .baud_rate      (baud_rate),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .supported      (supported),
        .divisor        (divisor),
        .scale_exponent (scale_exponent)
    );

    usart_baud_divisor_calc_checker #(.FREQ_BITS(FREQ_W)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .baud_rate      (baud_rate),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .supported      (supported),
        .divisor        (divisor),
        .scale_exponent (scale_exponent),
        .end_of_test    (end_of_test),
        .error_count    (error_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [FREQ_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_CLOCK_HZ)
            cur_clock_hz = value;
        else
            cur_double = value[0];
    endtask

    task automatic send_baud(input logic [BAUD_W-1:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        baud_rate <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    // The sender holds off until every transaction in flight has produced its result.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [BAUD_W-1:0] pick_baud(input longint unsigned clk_hz,
                                                    input logic dbl);
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned top_low;
        int unsigned     k;
        int unsigned     sel;
        logic [BAUD_W-1:0] b;
        hi = clk_hz / 8;
        lo = clk_hz / 4194304;
        if (!dbl)
        begin
            hi = hi / 2;
            lo = lo / 2;
        end
        if (hi > 24'hFFFFFF)
            hi = 24'hFFFFFF;
        top_low = lo * 40 + 1;
        if (top_low > hi)
            top_low = hi;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3: b = BAUD_W'($urandom_range(hi, lo));
            4, 5:
            begin
                k = $urandom_range(BAUD_W - 1);
                b = BAUD_W'((24'd1 << k) | ($urandom & ((24'd1 << k) - 1)));
            end
            6:
            begin
                case ($urandom_range(3))
                    0:       b = BAUD_W'(hi);
                    1:       b = BAUD_W'(hi + 1);
                    2:       b = BAUD_W'(lo);
                    default: b = BAUD_W'(lo - 1);
                endcase
            end
            7:       b = BAUD_W'($urandom);
            8:       b = BAUD_W'($urandom_range(top_low, lo));
            default: b = ($urandom_range(3) == 0) ? '0 : BAUD_W'($urandom_range(top_low, lo));
        endcase
        return b;
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_baud(24'd0);
        send_baud(24'd1);
        send_baud(24'd2);
        send_baud(24'd3);
        send_baud(24'd9600);
        send_baud(24'd115200);
        send_baud(24'd2000000);
        send_baud(24'd2000001);
        send_baud(24'hFFFFFF);
        drain();
        write_reg(REG_DOUBLE_SPEED, FREQ_W'(1));
        send_baud(24'd4000000);
        send_baud(24'd4000001);
        send_baud(24'd7);
        send_baud(24'd6);
        send_baud(24'd500000);
        drain();
        write_reg(REG_CLOCK_HZ, FREQ_W'(CLOCK_MAX));
        send_baud(24'd8388607);
        send_baud(24'd8388608);
        send_baud(24'd16);
        send_baud(24'd15);
        send_baud(24'hFFFFFF);
        drain();
        write_reg(REG_CLOCK_HZ, FREQ_W'(1));
        write_reg(REG_DOUBLE_SPEED, FREQ_W'(0));
        send_baud(24'd1);
        drain();
        write_reg(REG_CLOCK_HZ, FREQ_W'(0));
        send_baud(24'd1);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            sender_idle_pct = phase_idle[p];
            for (int s = 0; s < 6; s++)
            begin
                case (s)
                    0:       write_reg(REG_CLOCK_HZ, FREQ_W'(CLOCK_MAX));
                    1:       write_reg(REG_CLOCK_HZ, FREQ_W'(32000000));
                    2:       write_reg(REG_CLOCK_HZ, FREQ_W'($urandom_range(CLOCK_MAX, 1)));
                    3:       write_reg(REG_CLOCK_HZ, FREQ_W'($urandom_range(8388607, 4096)));
                    4:       write_reg(REG_CLOCK_HZ, FREQ_W'($urandom));
                    default: write_reg(REG_CLOCK_HZ,
                                       FREQ_W'($urandom_range(CLOCK_MAX, 33554432)));
                endcase
                write_reg(REG_DOUBLE_SPEED, FREQ_W'((s + p) % 2));
                repeat (SEGMENT_ITEMS)
                    send_baud(pick_baud(cur_clock_hz, cur_double));
                drain();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        end_of_test <= 1'b1;
        @(posedge clk);
        @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
